// ----- rtl/core/swmm_pkg.sv -----
`timescale 1ns / 1ps

package swmm_pkg;

  localparam int DefaultMaxDepth = 256;
  localparam int SampleWidth = 16;
  localparam int IndexWidth = 16;
  localparam int CountWidth = 9;
  localparam int LogWidth = 4;
  localparam logic [LogWidth-1:0] ResetLog2 = 4'd8;

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_MIN_READ,
    ST_MIN_FETCH,
    ST_MIN_CHECK,
    ST_MAX_READ,
    ST_MAX_FETCH,
    ST_MAX_CHECK,
    ST_APPEND,
    ST_FRONT_READ,
    ST_EVICT,
    ST_OUT_READ,
    ST_OUT_FETCH,
    ST_OUT_LOAD,
    ST_OUT_HOLD
  } state_t;

  typedef struct packed {
    logic clear;
    logic write_sample;
    logic min_read_back;
    logic min_pop_back;
    logic max_read_back;
    logic max_pop_back;
    logic append;
    logic front_read;
    logic evict;
    logic out_read;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic min_empty;
    logic min_worse;
    logic max_empty;
    logic max_worse;
  } status_t;

endpackage

// ----- rtl/core/swmm_ctrl.sv -----
`timescale 1ns / 1ps

module swmm_ctrl
  import swmm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    is_clear,
  input  status_t status,
  input  logic    out_taken,
  output logic    busy,
  output logic    out_valid,
  output ctrl_t   ctrl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (is_clear) begin
            ctrl.clear = 1'b1;
            state_next = ST_OUT_READ;
          end else begin
            state_next = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        ctrl.write_sample = 1'b1;
        state_next = ST_MIN_READ;
      end
      ST_MIN_READ: begin
        if (status.min_empty) begin
          state_next = ST_MAX_READ;
        end else begin
          ctrl.min_read_back = 1'b1;
          state_next = ST_MIN_FETCH;
        end
      end
      ST_MIN_FETCH: begin
        state_next = ST_MIN_CHECK;
      end
      ST_MIN_CHECK: begin
        if (status.min_worse) begin
          ctrl.min_pop_back = 1'b1;
          state_next = ST_MIN_READ;
        end else begin
          state_next = ST_MAX_READ;
        end
      end
      ST_MAX_READ: begin
        if (status.max_empty) begin
          state_next = ST_APPEND;
        end else begin
          ctrl.max_read_back = 1'b1;
          state_next = ST_MAX_FETCH;
        end
      end
      ST_MAX_FETCH: begin
        state_next = ST_MAX_CHECK;
      end
      ST_MAX_CHECK: begin
        if (status.max_worse) begin
          ctrl.max_pop_back = 1'b1;
          state_next = ST_MAX_READ;
        end else begin
          state_next = ST_APPEND;
        end
      end
      ST_APPEND: begin
        ctrl.append = 1'b1;
        state_next = ST_FRONT_READ;
      end
      ST_FRONT_READ: begin
        ctrl.front_read = 1'b1;
        state_next = ST_EVICT;
      end
      ST_EVICT: begin
        ctrl.evict = 1'b1;
        state_next = ST_OUT_READ;
      end
      ST_OUT_READ: begin
        ctrl.out_read = 1'b1;
        state_next = ST_OUT_FETCH;
      end
      ST_OUT_FETCH: begin
        state_next = ST_OUT_LOAD;
      end
      ST_OUT_LOAD: begin
        ctrl.out_load = 1'b1;
        state_next = ST_OUT_HOLD;
      end
      ST_OUT_HOLD: begin
        out_valid = 1'b1;
        if (out_taken) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/swmm_datapath.sv -----
`timescale 1ns / 1ps

module swmm_datapath
  import swmm_pkg::*;
#(
  parameter int MAX_DEPTH = DefaultMaxDepth
)
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [LogWidth-1:0]           cfg_log2,
  input  logic                          start,
  input  logic signed [SampleWidth-1:0] sample_in,
  input  ctrl_t                         ctrl,
  output status_t                       status,
  output logic signed [SampleWidth-1:0] latest,
  output logic signed [SampleWidth-1:0] window_min,
  output logic signed [SampleWidth-1:0] window_max,
  output logic [CountWidth-1:0]         fill_count
);

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int LenW = 17;
  localparam int DepthLog2 = $clog2(MAX_DEPTH);

  logic signed [SampleWidth-1:0] sample_mem [MAX_DEPTH];
  logic [IndexWidth-1:0] min_mem [MAX_DEPTH];
  logic [IndexWidth-1:0] max_mem [MAX_DEPTH];

  logic [LogWidth-1:0] log2_eff;
  logic [LenW-1:0] win_len;
  logic [LenW-1:0] len_mask;
  logic [IndexWidth-1:0] write_index;
  logic [LenW-1:0] held;
  logic [IndexWidth-1:0] min_head, min_tail, max_head, max_tail;
  logic [LenW-1:0] min_cnt, max_cnt;
  logic signed [SampleWidth-1:0] sample_reg;
  logic [IndexWidth-1:0] min_idx_rd, max_idx_rd;
  logic signed [SampleWidth-1:0] rd_min, rd_max;
  logic [IndexWidth-1:0] leaving_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      log2_eff <= (ResetLog2 > LogWidth'(DepthLog2)) ? LogWidth'(DepthLog2) : ResetLog2;
    end else if (cfg_write) begin
      log2_eff <= (cfg_log2 > LogWidth'(DepthLog2)) ? LogWidth'(DepthLog2) : cfg_log2;
    end
  end

  assign win_len = LenW'(1) << log2_eff;
  assign len_mask = win_len - LenW'(1);
  assign leaving_index = write_index - IndexWidth'(win_len);

  function automatic logic [AW-1:0] slot(input logic [IndexWidth-1:0] v,
                                         input logic [LenW-1:0] m);
    logic [LenW-1:0] w;
    begin
      w = LenW'(v) & m;
      slot = w[AW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (start) begin
      sample_reg <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.write_sample) begin
      sample_mem[slot(write_index, len_mask)] <= sample_reg;
    end
    if (ctrl.append) begin
      min_mem[slot(min_tail, len_mask)] <= write_index;
      max_mem[slot(max_tail, len_mask)] <= write_index;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.min_read_back) begin
      min_idx_rd <= min_mem[slot(min_tail - IndexWidth'(1), len_mask)];
    end else if (ctrl.front_read || ctrl.out_read) begin
      min_idx_rd <= min_mem[slot(min_head, len_mask)];
    end
    if (ctrl.max_read_back) begin
      max_idx_rd <= max_mem[slot(max_tail - IndexWidth'(1), len_mask)];
    end else if (ctrl.front_read || ctrl.out_read) begin
      max_idx_rd <= max_mem[slot(max_head, len_mask)];
    end
  end

  always_ff @(posedge clk) begin
    rd_min <= sample_mem[slot(min_idx_rd, len_mask)];
    rd_max <= sample_mem[slot(max_idx_rd, len_mask)];
  end

  assign status.min_empty = (min_cnt == '0);
  assign status.max_empty = (max_cnt == '0);
  assign status.min_worse = (rd_min > sample_reg);
  assign status.max_worse = (rd_max < sample_reg);

  always_ff @(posedge clk) begin
    if (rst || cfg_write || ctrl.clear) begin
      write_index <= '0;
      held <= '0;
      min_head <= '0;
      min_tail <= '0;
      min_cnt <= '0;
      max_head <= '0;
      max_tail <= '0;
      max_cnt <= '0;
    end else begin
      if (ctrl.min_pop_back) begin
        min_tail <= IndexWidth'(LenW'(min_tail - IndexWidth'(1)) & len_mask);
        min_cnt <= min_cnt - LenW'(1);
      end
      if (ctrl.max_pop_back) begin
        max_tail <= IndexWidth'(LenW'(max_tail - IndexWidth'(1)) & len_mask);
        max_cnt <= max_cnt - LenW'(1);
      end
      if (ctrl.append) begin
        min_tail <= IndexWidth'(LenW'(min_tail + IndexWidth'(1)) & len_mask);
        max_tail <= IndexWidth'(LenW'(max_tail + IndexWidth'(1)) & len_mask);
        if (min_cnt >= win_len) begin
          min_head <= IndexWidth'(LenW'(min_head + IndexWidth'(1)) & len_mask);
        end else begin
          min_cnt <= min_cnt + LenW'(1);
        end
        if (max_cnt >= win_len) begin
          max_head <= IndexWidth'(LenW'(max_head + IndexWidth'(1)) & len_mask);
        end else begin
          max_cnt <= max_cnt + LenW'(1);
        end
      end
      if (ctrl.evict) begin
        write_index <= write_index + IndexWidth'(1);
        if (held < win_len) begin
          held <= held + LenW'(1);
        end else begin
          if (min_cnt != '0 && min_idx_rd == leaving_index) begin
            min_head <= IndexWidth'(LenW'(min_head + IndexWidth'(1)) & len_mask);
            min_cnt <= min_cnt - LenW'(1);
          end
          if (max_cnt != '0 && max_idx_rd == leaving_index) begin
            max_head <= IndexWidth'(LenW'(max_head + IndexWidth'(1)) & len_mask);
            max_cnt <= max_cnt - LenW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      if (held == '0) begin
        latest <= '0;
        window_min <= '0;
        window_max <= '0;
      end else begin
        latest <= sample_reg;
        window_min <= rd_min;
        window_max <= rd_max;
      end
      fill_count <= CountWidth'(held);
    end
  end

endmodule

// ----- rtl/core/sliding_window_min_max.sv -----
`timescale 1ns / 1ps

// Sliding-window minimum and maximum over signed 16-bit samples, with a
// window of 2^window_log2 samples (limited to MAX_DEPTH rounded up to a
// power of two). Each transfer in gives one transfer out; the next is not
// accepted until that output is taken. A push writes the sample, pops
// worse entries from the back of each index queue, appends, evicts and
// loads the output; each push appends one entry to each queue, so pops
// average at most two per push. Push time is set by the compares: each one
// needs an index queue read followed by a registered read of the sample
// store. Writing window_log2 empties the window.
module sliding_window_min_max
  import swmm_pkg::*;
#(
  parameter int MAX_DEPTH = DefaultMaxDepth
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [LogWidth-1:0]   cfg_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // sample
  input  logic                  s_axis_tuser,  // cmd
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [63:0]           m_axis_tdata   // latest, window_min, window_max, fill_count
);

  logic start;
  logic busy;
  ctrl_t ctrl;
  status_t status;
  logic signed [SampleWidth-1:0] latest, window_min, window_max;
  logic [CountWidth-1:0] fill_count;

  assign s_axis_tready = !busy;
  assign start = s_axis_tvalid && s_axis_tready;

  swmm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .is_clear  (s_axis_tuser == CMD_CLEAR),
    .status    (status),
    .out_taken (m_axis_tready),
    .busy      (busy),
    .out_valid (m_axis_tvalid),
    .ctrl      (ctrl)
  );

  swmm_datapath #(.MAX_DEPTH(MAX_DEPTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_we),
    .cfg_log2   (cfg_wdata),
    .start      (start),
    .sample_in  (s_axis_tdata),
    .ctrl       (ctrl),
    .status     (status),
    .latest     (latest),
    .window_min (window_min),
    .window_max (window_max),
    .fill_count (fill_count)
  );

  assign m_axis_tdata = {7'd0, fill_count, window_max, window_min, latest};

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept during output");
  a_order: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid) else $error("repeat output");
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[31:16]) <= $signed(m_axis_tdata[47:32])))
    else $error("min above max");

endmodule
